>>> rtl/csp_pkg.sv
`timescale 1ns / 1ps
package csp_pkg;

  localparam int unsigned STACK_DEPTH_DEF   = 64;
  localparam int unsigned TABLE_ENTRIES_DEF = 128;
  localparam int unsigned ID_BITS_DEF       = 32;

  typedef enum logic [1:0] {
    OP_ENTER = 2'd0,
    OP_EXIT  = 2'd1,
    OP_FLUSH = 2'd2,
    OP_READ  = 2'd3
  } csp_op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_IGNORED   = 3'd1,
    ST_DROPPED   = 3'd2,
    ST_LOST      = 3'd3,
    ST_BAD_INDEX = 3'd4
  } csp_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_RD,
    S_CALC,
    S_UPD,
    S_OUT
  } csp_state_t;

  // Command broadcast to every table cell.
  typedef struct packed {
    logic upd;
    logic alloc;
  } csp_cell_ctl_t;

endpackage

>>> rtl/csp_cell.sv
`timescale 1ns / 1ps
module csp_cell import csp_pkg::*; #(
  parameter int unsigned IDX           = 0,
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int unsigned ID_BITS       = ID_BITS_DEF,
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic                clk,
  input  csp_cell_ctl_t       ctl,
  input  logic [CW-1:0]       used,
  input  logic [ID_BITS-1:0]  key,
  input  logic [ID_BITS-1:0]  wr_id,
  input  logic [63:0]         add_total,
  input  logic [63:0]         add_self,
  output logic                match,
  output logic [ID_BITS-1:0]  id,
  output logic [31:0]         calls,
  output logic [63:0]         total,
  output logic [63:0]         self_sum
);

  logic in_use;
  logic mine;

  assign in_use = CW'(IDX) < used;
  assign match  = in_use && (id == key);
  assign mine   = CW'(IDX) == used;

  // The cell that is hit accumulates in place; the first free cell takes a new id.
  always_ff @(posedge clk) begin
    if (ctl.upd && match) begin
      calls    <= calls + 32'd1;
      total    <= total + add_total;
      self_sum <= self_sum + add_self;
    end else if (ctl.alloc && mine) begin
      id       <= wr_id;
      calls    <= 32'd1;
      total    <= add_total;
      self_sum <= add_self;
    end
  end

endmodule

>>> rtl/csp_stack.sv
`timescale 1ns / 1ps
module csp_stack import csp_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned ID_BITS     = ID_BITS_DEF,
  localparam int unsigned AW = $clog2(STACK_DEPTH)
) (
  input  logic               clk,
  input  logic               fr_we,
  input  logic [AW-1:0]      fr_waddr,
  input  logic [ID_BITS-1:0] fr_wid,
  input  logic [63:0]        fr_wstart,
  input  logic [AW-1:0]      fr_raddr,
  output logic [ID_BITS-1:0] fr_rid,
  output logic [63:0]        fr_rstart,
  input  logic               ch_we,
  input  logic [AW-1:0]      ch_waddr,
  input  logic [63:0]        ch_wdata,
  input  logic [AW-1:0]      ch_raddr,
  output logic [63:0]        ch_rdata
);

  logic [ID_BITS-1:0] id_mem    [STACK_DEPTH];
  logic [63:0]        start_mem [STACK_DEPTH];
  logic [63:0]        child_mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (fr_we) begin
      id_mem[fr_waddr]    <= fr_wid;
      start_mem[fr_waddr] <= fr_wstart;
    end
    fr_rid    <= id_mem[fr_raddr];
    fr_rstart <= start_mem[fr_raddr];
  end

  always_ff @(posedge clk) begin
    if (ch_we) begin
      child_mem[ch_waddr] <= ch_wdata;
    end
    ch_rdata <= child_mem[ch_raddr];
  end

endmodule

>>> rtl/call_stack_time_profiler.sv
`timescale 1ns / 1ps
// Call-stack time profiler. An event is taken when start is high and busy is
// low; its one result appears on the result ports for a single cycle marked by
// done and cannot be held off by the receiver. Read, enter and ignored events
// go from dispatch straight to the output step. An exit closes one frame and a
// flush closes each open frame in turn; each frame close walks the stack memory
// read, the time arithmetic with the table compare, and the table
// and parent-frame update in turn. The frame stack lives in single-port-read
// memories; the function table is a row of cells that each compare their own id
// against the frame being closed and accumulate in place. Profiling is turned
// on through the enabled register at address 0; read events work always.
module call_stack_time_profiler import csp_pkg::*; #(
  parameter int unsigned STACK_DEPTH   = STACK_DEPTH_DEF,
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int unsigned ID_BITS       = ID_BITS_DEF,
  localparam int unsigned AW  = $clog2(STACK_DEPTH),
  localparam int unsigned DW  = $clog2(STACK_DEPTH + 1),
  localparam int unsigned SLW = $clog2(TABLE_ENTRIES),
  localparam int unsigned CW  = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [0:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  input  logic           start,
  output logic           busy,
  input  logic [1:0]     operation,
  input  logic [31:0]    function_id,
  input  logic [63:0]    timestamp,
  input  logic [SLW-1:0] entry_index,
  output logic           done,
  output logic [2:0]     status,
  output logic [SLW-1:0] entry_slot,
  output logic [31:0]    entry_id,
  output logic [31:0]    entry_calls,
  output logic [63:0]    entry_total,
  output logic [63:0]    entry_self,
  output logic [DW-1:0]  stack_depth,
  output logic [CW-1:0]  entry_count,
  output logic [31:0]    dropped_calls
);

  csp_state_t state, state_next;

  logic enabled;
  logic [DW-1:0] open_frames, open_frames_next;
  logic [CW-1:0] used, used_next;
  logic [31:0]   drops, drops_next;

  // Latched event.
  csp_op_t           op;
  logic [ID_BITS-1:0] fid;
  logic [63:0]       ts;
  logic [SLW-1:0]    idx;

  // Working registers of a frame close.
  logic [63:0]        tot, tot_next;
  logic [63:0]        slf, slf_next;
  logic [ID_BITS-1:0] cid, cid_next;
  logic               hit, hit_next;
  logic [SLW-1:0]     hit_slot, hit_slot_next;
  logic [SLW-1:0]     slot_r, slot_r_next;
  logic               rep, rep_next;
  csp_status_t        st, st_next;

  // Stack memory interface.
  logic               fr_we, ch_we;
  logic [AW-1:0]      fr_waddr, fr_raddr, ch_waddr, ch_raddr;
  logic [ID_BITS-1:0] fr_rid;
  logic [63:0]        fr_rstart, ch_wdata, ch_rdata;

  // Table row.
  csp_cell_ctl_t      ctl;
  logic [TABLE_ENTRIES-1:0] match;
  logic [ID_BITS-1:0] c_id    [TABLE_ENTRIES];
  logic [31:0]        c_calls [TABLE_ENTRIES];
  logic [63:0]        c_total [TABLE_ENTRIES];
  logic [63:0]        c_self  [TABLE_ENTRIES];
  logic [SLW-1:0]     match_slot;

  logic [63:0] diff;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {31'd0, enabled} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      enabled <= pwdata[0];
    end
  end

  csp_stack #(.STACK_DEPTH(STACK_DEPTH), .ID_BITS(ID_BITS)) u_stack (
    .clk(clk),
    .fr_we(fr_we), .fr_waddr(fr_waddr), .fr_wid(fid), .fr_wstart(ts),
    .fr_raddr(fr_raddr), .fr_rid(fr_rid), .fr_rstart(fr_rstart),
    .ch_we(ch_we), .ch_waddr(ch_waddr), .ch_wdata(ch_wdata),
    .ch_raddr(ch_raddr), .ch_rdata(ch_rdata)
  );

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    csp_cell #(.IDX(g), .TABLE_ENTRIES(TABLE_ENTRIES), .ID_BITS(ID_BITS)) u_cell (
      .clk(clk), .ctl(ctl), .used(used), .key(fr_rid), .wr_id(cid),
      .add_total(tot), .add_self(slf), .match(match[g]),
      .id(c_id[g]), .calls(c_calls[g]), .total(c_total[g]), .self_sum(c_self[g])
    );
  end

  // Table ids are unique, so at most one cell matches.
  always_comb begin
    match_slot = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (match[i]) begin
        match_slot = match_slot | SLW'(i);
      end
    end
  end

  assign diff = ts - fr_rstart;

  always_comb begin
    state_next       = state;
    open_frames_next = open_frames;
    used_next        = used;
    drops_next       = drops;
    tot_next         = tot;
    slf_next         = slf;
    cid_next         = cid;
    hit_next         = hit;
    hit_slot_next    = hit_slot;
    slot_r_next      = slot_r;
    rep_next         = rep;
    st_next          = st;
    fr_we            = 1'b0;
    fr_waddr         = open_frames[AW-1:0];
    fr_raddr         = AW'(open_frames - DW'(1));
    ch_we            = 1'b0;
    ch_waddr         = open_frames[AW-1:0];
    ch_wdata         = 64'd0;
    ch_raddr         = AW'(open_frames - DW'(1));
    ctl              = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        rep_next    = 1'b0;
        slot_r_next = '0;
        st_next     = ST_OK;
        state_next  = S_OUT;
        if (op == OP_READ) begin
          slot_r_next = idx;
          if (CW'(idx) < used) begin
            rep_next = 1'b1;
          end else begin
            st_next = ST_BAD_INDEX;
          end
        end else if (!enabled) begin
          st_next = ST_IGNORED;
        end else if (op == OP_ENTER) begin
          if (open_frames == DW'(STACK_DEPTH)) begin
            drops_next = drops + 32'd1;
            st_next    = ST_DROPPED;
          end else begin
            fr_we            = 1'b1;
            ch_we            = 1'b1;
            open_frames_next = open_frames + DW'(1);
          end
        end else if (open_frames == '0) begin
          if (op == OP_EXIT) begin
            st_next = ST_IGNORED;
          end
        end else begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        state_next = S_CALC;
      end
      S_CALC: begin
        tot_next      = diff;
        slf_next      = (diff > ch_rdata) ? diff - ch_rdata : 64'd0;
        cid_next      = fr_rid;
        hit_next      = |match;
        hit_slot_next = match_slot;
        ch_raddr      = AW'(open_frames - DW'(2));
        state_next    = S_UPD;
      end
      S_UPD: begin
        open_frames_next = open_frames - DW'(1);
        if (open_frames >= DW'(2)) begin
          ch_we    = 1'b1;
          ch_waddr = AW'(open_frames - DW'(2));
          ch_wdata = ch_rdata + tot;
        end
        if (hit) begin
          ctl.upd = 1'b1;
          if (op == OP_EXIT) begin
            rep_next    = 1'b1;
            slot_r_next = hit_slot;
          end
        end else if (used < CW'(TABLE_ENTRIES)) begin
          ctl.alloc = 1'b1;
          used_next = used + CW'(1);
          if (op == OP_EXIT) begin
            rep_next    = 1'b1;
            slot_r_next = SLW'(used);
          end
        end else begin
          st_next = ST_LOST;
        end
        if (op == OP_FLUSH && open_frames >= DW'(2)) begin
          state_next = S_RD;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      open_frames <= '0;
      used        <= '0;
      drops       <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      open_frames <= open_frames_next;
      used        <= used_next;
      drops       <= drops_next;
      done        <= (state == S_OUT);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op  <= csp_op_t'(operation);
      fid <= ID_BITS'(function_id);
      ts  <= timestamp;
      idx <= entry_index;
    end
    tot      <= tot_next;
    slf      <= slf_next;
    cid      <= cid_next;
    hit      <= hit_next;
    hit_slot <= hit_slot_next;
    slot_r   <= slot_r_next;
    rep      <= rep_next;
    st       <= st_next;
    if (state == S_OUT) begin
      status        <= st;
      entry_slot    <= slot_r;
      entry_id      <= rep ? 32'(c_id[slot_r]) : 32'd0;
      entry_calls   <= rep ? c_calls[slot_r] : 32'd0;
      entry_total   <= rep ? c_total[slot_r] : 64'd0;
      entry_self    <= rep ? c_self[slot_r] : 64'd0;
      stack_depth   <= open_frames;
      entry_count   <= used;
      dropped_calls <= drops;
    end
  end

  assign busy = (state != S_IDLE);

`ifndef NO_ASSERTIONS
  a_done_after_out: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_OUT)) else $error("result beat without output step");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy while a result beat is shown");
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    open_frames <= DW'(STACK_DEPTH)) else $error("stack depth overrun");
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CW'(TABLE_ENTRIES)) else $error("table count overrun");
`endif

endmodule
